@@ rtl/uif_pkg.sv @@
// Package for the unique item FIFO: sizes, status codes, ring index helper,
// and the command and status groups between controller and datapath.
// No dependencies.
`default_nettype none

package uif_pkg;

    // Storage geometry.
    localparam int DEPTH      = 16;
    localparam int ITEM_WIDTH = 16;
    localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W      = $clog2(DEPTH + 1);
    localparam int STATUS_W   = 3;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_NULL  = 3'd1,
        ST_DUP   = 3'd2,
        ST_FULL  = 3'd3,
        ST_EMPTY = 3'd4
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    start_scan;
        logic    scan;
        logic    rd_head;
        logic    push;
        logic    pop;
        logic    finish;
        status_t code;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mode;
        logic id_zero;
        logic full;
        logic empty;
        logic match;
        logic scan_done;
    } dp_stat_t;

    // Advance a ring index, wrapping from the last slot back to slot zero.
    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        if (idx == IDX_W'(DEPTH - 1))
            nxt = '0;
        else
            nxt = idx + IDX_W'(1);
        return nxt;
    endfunction

endpackage

`default_nettype wire

@@ rtl/uif_if.sv @@
// Channel interfaces of the unique item FIFO: request and response.
// Depends on uif_pkg.
`default_nettype none

// Request channel: one transaction is an insert or a remove.
interface uif_req_if;
    logic                            valid;
    logic                            ready;
    logic                            mode;
    logic [uif_pkg::ITEM_WIDTH-1:0]  item_id;

    modport source (output valid, output mode, output item_id, input ready);
    modport sink   (input valid, input mode, input item_id, output ready);
endinterface

// Response channel: one transaction per request.
interface uif_rsp_if;
    logic                            valid;
    logic                            ready;
    uif_pkg::status_t                status;
    logic [uif_pkg::ITEM_WIDTH-1:0]  item_out;
    logic [uif_pkg::LVL_W-1:0]       queue_level;

    modport source (output valid, output status, output item_out, output queue_level,
                    input ready);
    modport sink   (input valid, input status, input item_out, input queue_level,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/unique_item_fifo_top.sv @@
// Unique item FIFO: a queue of up to DEPTH nonzero identifiers that refuses
// duplicates. A request transaction either inserts item_id (mode 0) or
// removes the oldest entry (mode 1); each request yields exactly one response
// transaction with a status, the removed identifier (zero otherwise) and the
// queue level after the request. Requests are handled one at a time. A
// refused insert or an empty remove is answered from the check, a remove
// reads the head slot and then pops it, and an insert into an empty queue
// appends at once; any other insert first scans for a duplicate, and a
// duplicate found early ends the scan sooner. The duplicate scan reads one
// stored slot per cycle through the single read port of the slot memory,
// then compares the last slot and appends if none matched. The response
// sits in an output register; the next request is taken while one waits.
// Depends on uif_pkg, uif_if, uif_ctrl and uif_dp.
`default_nettype none

module unique_item_fifo_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    uif_req_if.sink    req,
    uif_rsp_if.source  rsp
);

    uif_pkg::ctrl_cmd_t cmd;
    uif_pkg::dp_stat_t  stat;

    // Sequencer.
    uif_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Storage, pointers and scan.
    uif_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .mode        (req.mode),
        .item_id     (req.item_id),
        .stat        (stat),
        .status      (rsp.status),
        .item_out    (rsp.item_out),
        .queue_level (rsp.queue_level)
    );

endmodule

`default_nettype wire

@@ rtl/uif_dp.sv @@
// Datapath of the unique item FIFO: slot memory, ring pointers, occupancy,
// duplicate scan and the response register. Depends on uif_pkg.
`default_nettype none

module uif_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire uif_pkg::ctrl_cmd_t              cmd,
    input  wire logic                            mode,
    input  wire logic [uif_pkg::ITEM_WIDTH-1:0]  item_id,
    output uif_pkg::dp_stat_t                    stat,
    output uif_pkg::status_t                     status,
    output logic [uif_pkg::ITEM_WIDTH-1:0]       item_out,
    output logic [uif_pkg::LVL_W-1:0]            queue_level
);

    // Slot memory.
    logic [uif_pkg::ITEM_WIDTH-1:0] mem [uif_pkg::DEPTH];

    // Latched request.
    logic                           mode_reg;
    logic [uif_pkg::ITEM_WIDTH-1:0] id_reg;

    // Ring state.
    logic [uif_pkg::IDX_W-1:0] head_reg, tail_reg;
    logic [uif_pkg::LVL_W-1:0] occ_reg, occ_next;

    // Scan state.
    logic [uif_pkg::IDX_W-1:0] scan_ptr_reg;
    logic [uif_pkg::LVL_W-1:0] issue_cnt_reg;
    logic                      cmp_pending_reg;
    logic                      scan_more;

    // Read port.
    logic [uif_pkg::ITEM_WIDTH-1:0] rd_data_reg;
    logic [uif_pkg::IDX_W-1:0]      rd_addr;
    logic                           rd_en;

    // Response register.
    uif_pkg::status_t               status_reg;
    logic [uif_pkg::ITEM_WIDTH-1:0] item_out_reg;
    logic [uif_pkg::LVL_W-1:0]      level_reg;

    // Capture the request on acceptance.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            id_reg   <= item_id;
        end
    end

    // Read address: the head for a remove, the scan pointer during a scan.
    assign scan_more = (issue_cnt_reg != occ_reg);
    assign rd_addr   = cmd.rd_head ? head_reg : scan_ptr_reg;
    assign rd_en     = cmd.rd_head || (cmd.scan && scan_more);

    // Memory write at the tail, registered read at one address.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            mem[tail_reg] <= id_reg;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Occupancy after this transaction.
    always_comb
    begin
        occ_next = occ_reg;
        if (cmd.push)
            occ_next = occ_reg + uif_pkg::LVL_W'(1);
        else if (cmd.pop)
            occ_next = occ_reg - uif_pkg::LVL_W'(1);
    end

    // Ring pointers, occupancy and scan counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg        <= '0;
            tail_reg        <= '0;
            occ_reg         <= '0;
            scan_ptr_reg    <= '0;
            issue_cnt_reg   <= '0;
            cmp_pending_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (cmd.push)
                tail_reg <= uif_pkg::ring_next(tail_reg);
            if (cmd.pop)
                head_reg <= uif_pkg::ring_next(head_reg);
            if (cmd.start_scan)
            begin
                scan_ptr_reg    <= head_reg;
                issue_cnt_reg   <= '0;
                cmp_pending_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                cmp_pending_reg <= scan_more;
                if (scan_more)
                begin
                    scan_ptr_reg  <= uif_pkg::ring_next(scan_ptr_reg);
                    issue_cnt_reg <= issue_cnt_reg + uif_pkg::LVL_W'(1);
                end
            end
        end
    end

    // Response payload, loaded when the controller finishes a request.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg   <= cmd.code;
            item_out_reg <= cmd.pop ? rd_data_reg : '0;
            level_reg    <= occ_next;
        end
    end

    // Status toward the controller.
    assign stat.mode      = mode_reg;
    assign stat.id_zero   = (id_reg == '0);
    assign stat.full      = (occ_reg == uif_pkg::LVL_W'(uif_pkg::DEPTH));
    assign stat.empty     = (occ_reg == '0);
    assign stat.match     = cmp_pending_reg && (rd_data_reg == id_reg);
    assign stat.scan_done = !scan_more && !cmp_pending_reg;

    assign status      = status_reg;
    assign item_out    = item_out_reg;
    assign queue_level = level_reg;

endmodule

`default_nettype wire

@@ rtl/uif_ctrl.sv @@
// Controller of the unique item FIFO: sequences check, scan and pop, and
// owns the request ready and response valid. Depends on uif_pkg.
`default_nettype none

module uif_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire uif_pkg::dp_stat_t   stat,
    output uif_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_POP
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;
    logic   out_valid_reg;
    logic   out_free;

    // The response register may be reloaded when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = uif_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!stat.mode)
                begin
                    // Insert: null first, then full, then empty (append at once), then the scan.
                    if (stat.id_zero)
                    begin
                        if (out_free)
                        begin
                            cmd.finish = 1'b1;
                            cmd.code   = uif_pkg::ST_NULL;
                            state_next = S_IDLE;
                        end
                    end
                    else if (stat.full)
                    begin
                        if (out_free)
                        begin
                            cmd.finish = 1'b1;
                            cmd.code   = uif_pkg::ST_FULL;
                            state_next = S_IDLE;
                        end
                    end
                    else if (stat.empty)
                    begin
                        if (out_free)
                        begin
                            cmd.push   = 1'b1;
                            cmd.finish = 1'b1;
                            cmd.code   = uif_pkg::ST_OK;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.start_scan = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
                else
                begin
                    // Remove: report empty or fetch the head slot.
                    if (stat.empty)
                    begin
                        if (out_free)
                        begin
                            cmd.finish = 1'b1;
                            cmd.code   = uif_pkg::ST_EMPTY;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.rd_head = 1'b1;
                        state_next  = S_POP;
                    end
                end
            end
            S_SCAN:
            begin
                if (stat.match)
                begin
                    if (out_free)
                    begin
                        cmd.finish = 1'b1;
                        cmd.code   = uif_pkg::ST_DUP;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.scan_done)
                begin
                    if (out_free)
                    begin
                        cmd.push   = 1'b1;
                        cmd.finish = 1'b1;
                        cmd.code   = uif_pkg::ST_OK;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            S_POP:
            begin
                if (out_free)
                begin
                    cmd.pop    = 1'b1;
                    cmd.finish = 1'b1;
                    cmd.code   = uif_pkg::ST_OK;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered handshake outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ rtl/uif_checker.sv @@
// Port-level checks for the unique item FIFO, bound to the top level.
// Depends on uif_pkg and unique_item_fifo_top.
`default_nettype none

module uif_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            req_valid,
    input wire logic                            req_ready,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_ready,
    input wire logic [uif_pkg::STATUS_W-1:0]    status,
    input wire logic [uif_pkg::ITEM_WIDTH-1:0]  item_out,
    input wire logic [uif_pkg::LVL_W-1:0]       queue_level
);

    // A stalled response keeps its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(item_out)
            && $stable(queue_level))
        else $error("response changed while stalled");

    // Requests are taken one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted back to back");

    // Only a successful remove carries an identifier.
    a_item_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != uif_pkg::ST_OK) |-> item_out == '0)
        else $error("identifier returned with a failing status");

    // An empty report leaves the level at zero.
    a_empty_level: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == uif_pkg::ST_EMPTY) |-> queue_level == '0)
        else $error("empty status with nonzero level");

    // The level never exceeds the capacity.
    a_level_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> queue_level <= uif_pkg::LVL_W'(uif_pkg::DEPTH))
        else $error("queue level above capacity");

endmodule

bind unique_item_fifo_top uif_checker u_uif_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .item_out    (rsp.item_out),
    .queue_level (rsp.queue_level)
);

`default_nettype wire
